### rtl/u2j_pkg.sv
`timescale 1ns / 1ps
package u2j_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharLowerU    = 8'h75;

  localparam logic [3:0] IdxEscLast  = 4'd5;
  localparam logic [3:0] IdxHalf     = 4'd6;
  localparam logic [3:0] IdxPairLast = 4'd11;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_ESC,
    CMD_PAIR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        err;
    logic [15:0] word_hi;
    logic [15:0] word_lo;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

### rtl/u2j_front.sv
`timescale 1ns / 1ps
module u2j_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  output logic          cmd_valid_o,
  output u2j_pkg::cmd_t cmd_o
);
  import u2j_pkg::*;

  logic [20:0] acc_q, acc_d;
  logic [1:0]  rem_q, rem_d;
  logic        err_q, err_d;

  logic [20:0] acc_shift;
  logic [20:0] cp;
  logic        emit_cp;
  logic [20:0] cp_off;

  assign acc_shift = {acc_q[14:0], in_byte_i[5:0]};
  assign cp_off    = cp - 21'h10000;

  always_comb begin
    acc_d       = acc_q;
    rem_d       = rem_q;
    err_d       = err_q;
    cp          = {13'h0, in_byte_i};
    emit_cp     = 1'b0;
    cmd_valid_o = 1'b0;
    cmd_o       = '{kind: CMD_BYTE, err: 1'b0, word_hi: 16'h0, word_lo: 16'h0};
    if (in_byte_i == 8'h00) begin
      cmd_valid_o   = 1'b1;
      cmd_o.err     = err_q | (rem_q != 2'd0);
      acc_d         = '0;
      rem_d         = '0;
      err_d         = 1'b0;
    end else if (err_q) begin
      acc_d = acc_q;
    end else if (rem_q != 2'd0) begin
      if (in_byte_i[7:6] != 2'b10) begin
        err_d = 1'b1;
        rem_d = '0;
        acc_d = '0;
      end else begin
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          cp      = acc_shift;
          emit_cp = 1'b1;
          acc_d   = '0;
        end else begin
          acc_d = acc_shift;
        end
      end
    end else if (in_byte_i[7] == 1'b0) begin
      emit_cp = 1'b1;
    end else if (in_byte_i[7:5] == 3'b110) begin
      acc_d = {16'h0, in_byte_i[4:0]};
      rem_d = 2'd1;
    end else if (in_byte_i[7:4] == 4'b1110) begin
      acc_d = {17'h0, in_byte_i[3:0]};
      rem_d = 2'd2;
    end else if (in_byte_i[7:3] == 5'b11110) begin
      acc_d = {18'h0, in_byte_i[2:0]};
      rem_d = 2'd3;
    end else begin
      err_d = 1'b1;
    end

    if (emit_cp) begin
      cmd_valid_o = 1'b1;
      if (cp[20:7] == 14'h0) begin
        cmd_o.kind    = CMD_BYTE;
        cmd_o.word_hi = {8'h0, cp[7:0]};
      end else if (cp[20:16] != 5'h0) begin
        cmd_o.kind    = CMD_PAIR;
        cmd_o.word_hi = {6'b110110, cp_off[19:10]};
        cmd_o.word_lo = {6'b110111, cp_off[9:0]};
      end else begin
        cmd_o.kind    = CMD_ESC;
        cmd_o.word_hi = cp[15:0];
      end
    end

    if (!accept_i) begin
      acc_d       = acc_q;
      rem_d       = rem_q;
      err_d       = err_q;
      cmd_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= '0;
      err_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      rem_q <= rem_d;
      err_q <= err_d;
    end
  end

endmodule

### rtl/u2j_queue.sv
`timescale 1ns / 1ps
module u2j_queue #(
  parameter int unsigned Depth = u2j_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  u2j_pkg::cmd_t wr_data_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output logic          rd_valid_o,
  output u2j_pkg::cmd_t rd_data_o
);
  import u2j_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == FullCnt);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/u2j_back.sv
`timescale 1ns / 1ps
module u2j_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  u2j_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o,
  output logic          decode_error_o
);
  import u2j_pkg::*;

  logic [3:0]  idx_q, idx_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        err_q, err_d;

  logic        load;
  logic        is_last;
  logic        second_half;
  logic [15:0] word;
  logic [3:0]  pos;
  logic [3:0]  nib;
  logic [7:0]  esc_byte;

  assign load        = cmd_valid_i && (!out_valid_q || pop_i);
  assign second_half = (idx_q >= IdxHalf);
  assign word        = second_half ? cmd_i.word_lo : cmd_i.word_hi;
  assign pos         = second_half ? idx_q - IdxHalf : idx_q;

  always_comb begin
    case (pos)
      4'd2:    nib = word[15:12];
      4'd3:    nib = word[11:8];
      4'd4:    nib = word[7:4];
      default: nib = word[3:0];
    endcase
    case (pos)
      4'd0:    esc_byte = CharBackslash;
      4'd1:    esc_byte = CharLowerU;
      default: esc_byte = hex_char(nib);
    endcase
  end

  always_comb begin
    case (cmd_i.kind)
      CMD_BYTE: is_last = 1'b1;
      CMD_ESC:  is_last = (idx_q == IdxEscLast);
      CMD_PAIR: is_last = (idx_q == IdxPairLast);
      default:  is_last = 1'b1;
    endcase
  end

  assign cmd_pop_o = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    err_d       = err_q;
    if (out_valid_q && pop_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_last ? '0 : idx_q + 4'd1;
      last_d      = is_last;
      if (cmd_i.kind == CMD_BYTE) begin
        byte_d = cmd_i.word_hi[7:0];
        err_d  = cmd_i.err;
      end else begin
        byte_d = esc_byte;
        err_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign empty_o        = !out_valid_q;
  assign out_byte_o     = byte_q;
  assign last_of_run_o  = last_q;
  assign decode_error_o = err_q;

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxPairLast)
    else $error("expansion index out of range");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> idx_q == '0)
    else $error("expansion index nonzero without a command");

  a_err_on_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && err_q |-> byte_q == 8'h00 && last_q)
    else $error("error flag set on a byte that is not a terminator");

  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> out_valid_q && last_q)
    else $error("command retired without a final byte");
`endif

endmodule

### rtl/utf8_to_json_unicode_escape_unit.sv
// Datapath: an accepted input byte is decoded combinationally into a command that is
// written into the command queue; the back end then registers each output byte for the ports.
// Throughput: one input byte per cycle while the queue is not full; the output stage
// emits one byte per cycle while pop is asserted, so a code point costs 1, 6 or 12 output
// bytes and the input stalls when the two-entry command queue fills behind a long escape.
// Reset: asynchronous, active low; decoder state, queue pointers and output valid state clear.
`timescale 1ns / 1ps
module utf8_to_json_unicode_escape_unit #(
  parameter int unsigned QueueDepth = u2j_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       decode_error_o
);
  import u2j_pkg::*;

  logic accept;
  logic wr_en;
  cmd_t wr_cmd;
  logic q_full;
  logic rd_valid;
  cmd_t rd_cmd;
  logic rd_en;

  assign full   = q_full;
  assign accept = push && !q_full;

  u2j_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .cmd_valid_o (wr_en),
    .cmd_o       (wr_cmd)
  );

  u2j_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_data_i  (wr_cmd),
    .full_o     (q_full),
    .rd_en_i    (rd_en),
    .rd_valid_o (rd_valid),
    .rd_data_o  (rd_cmd)
  );

  u2j_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (rd_valid),
    .cmd_i          (rd_cmd),
    .cmd_pop_o      (rd_en),
    .empty_o        (empty),
    .pop_i          (pop),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .decode_error_o (decode_error_o)
  );

endmodule
